>>> src/tmbe_pkg.sv
// Package for the traffic matrix balance engine.
// Holds the port word types, command and result codes, sequencer states.
// No dependencies.
package tmbe_pkg;

    localparam int MAX_DIM_DEF = 16;
    localparam logic [4:0] DIM_RESET = 5'd16;

    localparam logic [2:0] CMD_SET     = 3'd0;
    localparam logic [2:0] CMD_ADD     = 3'd1;
    localparam logic [2:0] CMD_SUB     = 3'd2;
    localparam logic [2:0] CMD_GET     = 3'd3;
    localparam logic [2:0] CMD_SCALE   = 3'd4;
    localparam logic [2:0] CMD_CLEAR   = 3'd5;
    localparam logic [2:0] CMD_ANALYZE = 3'd6;

    localparam logic [1:0] KIND_REPLY = 2'd0;
    localparam logic [1:0] KIND_ROW   = 2'd1;
    localparam logic [1:0] KIND_COL   = 2'd2;
    localparam logic [1:0] KIND_SUM   = 2'd3;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [4:0]  row;
        logic [4:0]  col;
        logic [63:0] value;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  line_index;
        logic [63:0] data;
        logic        ok;
        logic        at_max;
        logic        balanced;
        logic [63:0] unit_out;
        logic        last;
    } t_out_word;

    typedef enum logic {
        ALU_DIV,
        ALU_MUL
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_alu_sts;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_ACC_RD,
        S_ACC_WR,
        S_REPLY,
        S_SC_RD,
        S_SC_CHK,
        S_SC_DIV,
        S_SC_MUL,
        S_AN_RD,
        S_AN_ACC,
        S_EM_RD,
        S_EM_OUT,
        S_EM_SUM
    } t_state;

endpackage

>>> src/tmbe_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tmbe_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/tmbe_arith.sv
// Shared iterative arithmetic unit: 64-bit restoring divide or wrapping
// multiply, one bit per cycle. Depends on tmbe_pkg.
module tmbe_arith
    import tmbe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_alu_req    i_req,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output t_alu_sts    o_sts,
    output logic [63:0] o_result
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    t_alu_op     r_op, n_op;
    logic [5:0]  r_cnt, n_cnt;
    logic [63:0] r_a, n_a;
    logic [63:0] r_b, n_b;
    logic [63:0] r_acc, n_acc;
    logic [64:0] rem_sh;
    logic [64:0] rem_diff;

    assign rem_sh   = {r_acc, r_a[63]};
    assign rem_diff = rem_sh - {1'b0, r_b};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_a    = r_a;
        n_b    = r_b;
        n_acc  = r_acc;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_op   = i_req.op;
            n_cnt  = '0;
            n_a    = i_a;
            n_b    = i_b;
            n_acc  = '0;
        end else if (r_busy) begin
            if (r_op == ALU_DIV) begin
                if (!rem_diff[64]) begin
                    n_acc = rem_diff[63:0];
                end else begin
                    n_acc = rem_sh[63:0];
                end
                n_a = {r_a[62:0], ~rem_diff[64]};
            end else begin
                if (r_b[0]) begin
                    n_acc = r_acc + r_a;
                end
                n_a = {r_a[62:0], 1'b0};
                n_b = {1'b0, r_b[63:1]};
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd63) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_op  <= n_op;
        r_cnt <= n_cnt;
        r_a   <= n_a;
        r_b   <= n_b;
        r_acc <= n_acc;
    end

    assign o_sts    = '{busy: r_busy, done: r_done};
    assign o_result = (r_op == ALU_DIV) ? r_a : r_acc;

endmodule

>>> src/traffic_matrix_balance_engine.sv
// Top level of the traffic matrix balance engine: sequencer, matrix and line-sum RAMs.
// Depends on tmbe_pkg, tmbe_ram, tmbe_arith.
//
//  channel | valid      | ready       | word
//  --------+------------+-------------+-------------------
//  in      | i_in_valid | o_in_ready  | i_in_word (t_in_word)
//  out     | o_out_valid| i_out_ready | o_out_word (t_out_word)
//  cfg     | i_cfg_valid| o_cfg_ready | i_cfg_data (dim)
//
// Set/add/sub/get: one RAM read, a RAM write for set/add/sub, then the reply word.
// Scale: all 2^(2*ceil(log2 MAX_DIM)) entries are read in turn; each nonzero entry goes
// through the shared bit-serial divider, then the unit multiply runs and the reply is sent.
// Clear writes one entry per cycle. Analyze sums every row and column, then emits them.
// After reset a clearing pass writes one entry per cycle over all 2^(2*ceil(log2 MAX_DIM))
// entries with o_in_ready low. One word in work at a time; a finished word may
// wait in the output register while the next is accepted.
module traffic_matrix_balance_engine
    import tmbe_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [4:0] i_cfg_data
);

    localparam int RW     = $clog2(MAX_DIM);
    localparam int EAW    = 2 * RW;
    localparam int EDEPTH = 1 << EAW;
    localparam int LDEPTH = 2 * MAX_DIM;
    localparam int LAW    = $clog2(LDEPTH);
    localparam int NW     = $clog2(MAX_DIM + 1);
    localparam int LCW    = $clog2(2 * MAX_DIM + 1);

    t_state           r_state, n_state;
    logic [2:0]       r_cmd, n_cmd;
    logic [63:0]      r_val, n_val;
    logic [EAW-1:0]   r_addr, n_addr;
    logic [RW-1:0]    r_k, n_k;
    logic [LCW-1:0]   r_line, n_line;
    logic [63:0]      r_acc, n_acc;
    logic [63:0]      r_max, n_max;
    logic             r_bal, n_bal;
    logic [63:0]      r_unit, n_unit;
    logic [63:0]      r_data, n_data;
    logic             r_ok, n_ok;
    logic [4:0]       r_dim;
    logic             r_clr_reply, n_clr_reply;
    logic             r_ovalid;
    t_out_word        r_oword, n_oword;
    logic             out_load;

    logic [NW-1:0]    use_dim;
    logic [4:0]       use_dim5;
    logic [LCW-1:0]   use_dim_l;
    logic [LCW-1:0]   last_line;
    logic [RW-1:0]    k_end;
    logic             is_row;
    logic [LCW-1:0]   loff;
    logic [EAW-1:0]   an_addr;
    logic             out_free;
    logic [63:0]      sum;

    logic             e_we, e_re;
    logic [EAW-1:0]   e_waddr, e_raddr;
    logic [63:0]      e_wdata, e_rdata;
    logic             l_we, l_re;
    logic [LAW-1:0]   l_addr;
    logic [63:0]      l_rdata;

    t_alu_req         alu_req;
    t_alu_sts         alu_sts;
    logic [63:0]      alu_a, alu_b, alu_res;

    tmbe_ram #(.WIDTH(64), .DEPTH(EDEPTH)) u_entries (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (e_waddr),
        .i_wdata (e_wdata),
        .i_re    (e_re),
        .i_raddr (e_raddr),
        .o_rdata (e_rdata)
    );

    tmbe_ram #(.WIDTH(64), .DEPTH(LDEPTH)) u_line_sums (
        .i_clk   (i_clk),
        .i_we    (l_we),
        .i_waddr (l_addr),
        .i_wdata (sum),
        .i_re    (l_re),
        .i_raddr (l_addr),
        .o_rdata (l_rdata)
    );

    tmbe_arith u_arith (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (alu_req),
        .i_a      (alu_a),
        .i_b      (alu_b),
        .o_sts    (alu_sts),
        .o_result (alu_res)
    );

    assign use_dim   = (r_dim > 5'(MAX_DIM)) ? NW'(MAX_DIM) : r_dim[NW-1:0];
    assign use_dim5  = 5'(use_dim);
    assign use_dim_l = LCW'(use_dim);
    assign last_line = (use_dim_l << 1) - LCW'(1);
    assign k_end     = RW'(use_dim - NW'(1));
    assign is_row    = r_line < use_dim_l;
    assign loff      = is_row ? r_line : r_line - use_dim_l;
    assign an_addr   = is_row ? {loff[RW-1:0], r_k} : {r_k, loff[RW-1:0]};
    assign out_free  = !r_ovalid || i_out_ready;
    assign sum       = r_acc + e_rdata;
    assign l_addr    = r_line[LAW-1:0];

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_val       = r_val;
        n_addr      = r_addr;
        n_k         = r_k;
        n_line      = r_line;
        n_acc       = r_acc;
        n_max       = r_max;
        n_bal       = r_bal;
        n_unit      = r_unit;
        n_data      = r_data;
        n_ok        = r_ok;
        n_clr_reply = r_clr_reply;
        n_oword     = r_oword;
        out_load    = 1'b0;
        e_we        = 1'b0;
        e_re        = 1'b0;
        e_waddr     = r_addr;
        e_raddr     = r_addr;
        e_wdata     = '0;
        l_we        = 1'b0;
        l_re        = 1'b0;
        alu_req     = '{start: 1'b0, op: ALU_DIV};
        alu_a       = e_rdata - 64'd1;
        alu_b       = r_val;

        unique case (r_state)
            S_CLR: begin
                e_we   = 1'b1;
                n_addr = r_addr + EAW'(1);
                if (r_addr == '1) begin
                    n_unit      = 64'd1;
                    n_max       = '0;
                    n_clr_reply = 1'b0;
                    n_data      = '0;
                    n_ok        = 1'b1;
                    n_state     = r_clr_reply ? S_REPLY : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd  = i_in_word.cmd;
                    n_val  = i_in_word.value;
                    n_addr = {i_in_word.row[RW-1:0], i_in_word.col[RW-1:0]};
                    n_data = '0;
                    n_ok   = 1'b0;
                    case (i_in_word.cmd) inside
                        CMD_SET, CMD_ADD, CMD_SUB, CMD_GET: begin
                            if (i_in_word.row < use_dim5 && i_in_word.col < use_dim5) begin
                                n_state = S_ACC_RD;
                            end else begin
                                n_state = S_REPLY;
                            end
                        end
                        CMD_SCALE: begin
                            n_addr  = '0;
                            n_state = (i_in_word.value == '0) ? S_REPLY : S_SC_RD;
                        end
                        CMD_CLEAR: begin
                            n_addr      = '0;
                            n_clr_reply = 1'b1;
                            n_state     = S_CLR;
                        end
                        CMD_ANALYZE: begin
                            n_line  = '0;
                            n_k     = '0;
                            n_acc   = '0;
                            n_max   = '0;
                            n_bal   = 1'b1;
                            n_state = (use_dim == '0) ? S_EM_SUM : S_AN_RD;
                        end
                        default: begin
                            n_state = S_REPLY;
                        end
                    endcase
                end
            end
            S_ACC_RD: begin
                e_re    = 1'b1;
                n_state = S_ACC_WR;
            end
            S_ACC_WR: begin
                unique case (r_cmd)
                    CMD_SET: begin
                        e_we    = 1'b1;
                        e_wdata = r_val;
                    end
                    CMD_ADD: begin
                        e_we    = 1'b1;
                        e_wdata = e_rdata + r_val;
                    end
                    CMD_SUB: begin
                        e_we    = 1'b1;
                        e_wdata = e_rdata - r_val;
                    end
                    default: begin
                        n_data = e_rdata;
                    end
                endcase
                n_ok    = 1'b1;
                n_state = S_REPLY;
            end
            S_REPLY: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_oword  = '{kind: KIND_REPLY, line_index: '0, data: r_data, ok: r_ok,
                                 at_max: 1'b0, balanced: 1'b0, unit_out: r_unit,
                                 last: 1'b1};
                    n_state  = S_IDLE;
                end
            end
            S_SC_RD: begin
                e_re    = 1'b1;
                n_state = S_SC_CHK;
            end
            S_SC_CHK: begin
                if (e_rdata != '0) begin
                    alu_req.start = 1'b1;
                    n_state       = S_SC_DIV;
                end else if (r_addr == '1) begin
                    alu_req = '{start: 1'b1, op: ALU_MUL};
                    alu_a   = r_unit;
                    n_state = S_SC_MUL;
                end else begin
                    n_addr  = r_addr + EAW'(1);
                    n_state = S_SC_RD;
                end
            end
            S_SC_DIV: begin
                if (alu_sts.done) begin
                    e_we    = 1'b1;
                    e_wdata = alu_res + 64'd1;
                    if (r_addr == '1) begin
                        alu_req = '{start: 1'b1, op: ALU_MUL};
                        alu_a   = r_unit;
                        n_state = S_SC_MUL;
                    end else begin
                        n_addr  = r_addr + EAW'(1);
                        n_state = S_SC_RD;
                    end
                end
            end
            S_SC_MUL: begin
                if (alu_sts.done) begin
                    n_unit  = alu_res;
                    n_data  = '0;
                    n_ok    = 1'b1;
                    n_state = S_REPLY;
                end
            end
            S_AN_RD: begin
                e_re    = 1'b1;
                e_raddr = an_addr;
                n_state = S_AN_ACC;
            end
            S_AN_ACC: begin
                n_state = S_AN_RD;
                if (r_k == k_end) begin
                    l_we  = 1'b1;
                    n_acc = '0;
                    n_k   = '0;
                    if (sum > r_max) begin
                        n_max = sum;
                    end
                    if (r_line == last_line) begin
                        n_line  = '0;
                        n_state = S_EM_RD;
                    end else begin
                        n_line = r_line + LCW'(1);
                    end
                end else begin
                    n_acc = sum;
                    n_k   = r_k + RW'(1);
                end
            end
            S_EM_RD: begin
                l_re    = 1'b1;
                n_state = S_EM_OUT;
            end
            S_EM_OUT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_oword  = '{kind: is_row ? KIND_ROW : KIND_COL, line_index: 4'(loff),
                                 data: l_rdata, ok: 1'b1, at_max: l_rdata == r_max,
                                 balanced: 1'b0, unit_out: '0, last: 1'b0};
                    if (l_rdata != r_max) begin
                        n_bal = 1'b0;
                    end
                    if (r_line == last_line) begin
                        n_state = S_EM_SUM;
                    end else begin
                        n_line  = r_line + LCW'(1);
                        n_state = S_EM_RD;
                    end
                end
            end
            S_EM_SUM: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_oword  = '{kind: KIND_SUM, line_index: '0, data: r_max, ok: 1'b1,
                                 at_max: 1'b0, balanced: r_bal, unit_out: r_unit,
                                 last: 1'b1};
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_addr      <= '0;
            r_clr_reply <= 1'b0;
            r_unit      <= 64'd1;
            r_max       <= '0;
            r_dim       <= DIM_RESET;
            r_ovalid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_clr_reply <= n_clr_reply;
            r_unit      <= n_unit;
            r_max       <= n_max;
            if (i_cfg_valid) begin
                r_dim <= i_cfg_data;
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
        r_cmd   <= n_cmd;
        r_val   <= n_val;
        r_k     <= n_k;
        r_line  <= n_line;
        r_acc   <= n_acc;
        r_bal   <= n_bal;
        r_data  <= n_data;
        r_ok    <= n_ok;
        r_oword <= n_oword;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_word  = r_oword;
    assign o_cfg_ready = 1'b1;

    a_idle_alu_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !alu_sts.busy)
        else $error("arith unit busy while idle");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_ovalid || i_out_ready))
        else $error("output word overwritten");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second word accepted while busy");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_sts.done |-> (r_state == S_SC_DIV || r_state == S_SC_MUL))
        else $error("arith result outside a wait state");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// Testbench for traffic_matrix_balance_engine: directed table, then random words,
// all checked against an in-bench matrix predictor. Depends on tmbe_pkg.
module tb;
    import tmbe_pkg::*;

    localparam int N_DIR = 24;
    localparam int N_RAND = 480;
    localparam int WD_LIMIT = 400000;

    typedef struct {
        t_in_word w;
        logic     has_exp;
        logic [63:0] exp_data;
        logic     exp_ok;
    } t_dir_row;

    logic clk;
    logic rst_n;
    logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
    t_in_word in_word;
    t_out_word out_word;
    logic [4:0] cfg_data;

    logic [63:0] mat [16][16];
    logic [63:0] scale_unit;
    logic [4:0] dim_reg;
    t_out_word expect_q [$];
    int errors, n_sent, n_recv, idle_cycles;
    bit hold_out, no_idle;

    traffic_matrix_balance_engine dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_word(in_word),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_word(out_word),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data)
    );

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic t_out_word mk(logic [1:0] k, logic [3:0] li, logic [63:0] d,
                                     logic ok, logic am, logic bal, logic [63:0] u,
                                     logic lst);
        t_out_word r;
        r.kind = k; r.line_index = li; r.data = d; r.ok = ok; r.at_max = am;
        r.balanced = bal; r.unit_out = u; r.last = lst;
        return r;
    endfunction

    task automatic predict_word(input t_in_word w);
        int n;
        logic [63:0] rs [16];
        logic [63:0] cs [16];
        logic [63:0] mx, rd;
        logic bal;
        n = (dim_reg > 16) ? 16 : dim_reg;
        case (w.cmd)
            CMD_SET, CMD_ADD, CMD_SUB, CMD_GET: begin
                if (w.row >= n || w.col >= n) begin
                    expect_q.push_back(mk(KIND_REPLY, 0, 0, 0, 0, 0, scale_unit, 1));
                end else begin
                    rd = 0;
                    case (w.cmd)
                        CMD_SET: mat[w.row][w.col] = w.value;
                        CMD_ADD: mat[w.row][w.col] = mat[w.row][w.col] + w.value;
                        CMD_SUB: mat[w.row][w.col] = mat[w.row][w.col] - w.value;
                        default: rd = mat[w.row][w.col];
                    endcase
                    expect_q.push_back(mk(KIND_REPLY, 0, rd, 1, 0, 0, scale_unit, 1));
                end
            end
            CMD_SCALE: begin
                if (w.value == 0) begin
                    expect_q.push_back(mk(KIND_REPLY, 0, 0, 0, 0, 0, scale_unit, 1));
                end else begin
                    for (int i = 0; i < 16; i++)
                        for (int j = 0; j < 16; j++)
                            if (mat[i][j] != 0) mat[i][j] = (mat[i][j] - 1) / w.value + 1;
                    scale_unit = scale_unit * w.value;
                    expect_q.push_back(mk(KIND_REPLY, 0, 0, 1, 0, 0, scale_unit, 1));
                end
            end
            CMD_CLEAR: begin
                for (int i = 0; i < 16; i++)
                    for (int j = 0; j < 16; j++) mat[i][j] = 0;
                scale_unit = 1;
                expect_q.push_back(mk(KIND_REPLY, 0, 0, 1, 0, 0, scale_unit, 1));
            end
            CMD_ANALYZE: begin
                mx = 0;
                bal = 1;
                for (int i = 0; i < n; i++) begin
                    rs[i] = 0; cs[i] = 0;
                    for (int j = 0; j < n; j++) begin
                        rs[i] = rs[i] + mat[i][j];
                        cs[i] = cs[i] + mat[j][i];
                    end
                    if (rs[i] > mx) mx = rs[i];
                    if (cs[i] > mx) mx = cs[i];
                end
                for (int i = 0; i < n; i++) begin
                    if (rs[i] != mx) bal = 0;
                    expect_q.push_back(mk(KIND_ROW, 4'(i), rs[i], 1, rs[i] == mx, 0, 0, 0));
                end
                for (int i = 0; i < n; i++) begin
                    if (cs[i] != mx) bal = 0;
                    expect_q.push_back(mk(KIND_COL, 4'(i), cs[i], 1, cs[i] == mx, 0, 0, 0));
                end
                expect_q.push_back(mk(KIND_SUM, 0, mx, 1, 0, bal, scale_unit, 1));
            end
            default: expect_q.push_back(mk(KIND_REPLY, 0, 0, 0, 0, 0, scale_unit, 1));
        endcase
    endtask

    task automatic check_word(input t_out_word got);
        t_out_word e;
        if (expect_q.size() == 0) begin
            $error("unexpected word kind=%0d data=%h", got.kind, got.data);
            errors++;
            return;
        end
        e = expect_q.pop_front();
        if (got.kind !== e.kind) begin
            $error("kind exp %0d got %0d", e.kind, got.kind); errors++;
        end
        if (got.line_index !== e.line_index) begin
            $error("line_index exp %0d got %0d", e.line_index, got.line_index); errors++;
        end
        if (got.data !== e.data) begin
            $error("data exp %h got %h", e.data, got.data); errors++;
        end
        if (got.ok !== e.ok) begin
            $error("ok exp %0b got %0b", e.ok, got.ok); errors++;
        end
        if (got.at_max !== e.at_max) begin
            $error("at_max exp %0b got %0b", e.at_max, got.at_max); errors++;
        end
        if (got.balanced !== e.balanced) begin
            $error("balanced exp %0b got %0b", e.balanced, got.balanced); errors++;
        end
        if (got.unit_out !== e.unit_out) begin
            $error("unit_out exp %h got %h", e.unit_out, got.unit_out); errors++;
        end
        if (got.last !== e.last) begin
            $error("last exp %0b got %0b", e.last, got.last); errors++;
        end
    endtask

    // receiver: random stalls, plus a long hold-off when requested
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            check_word(out_word);
            n_recv++;
        end
        if (hold_out) out_ready <= 1'b0;
        else if (no_idle) out_ready <= 1'b1;
        else out_ready <= ($urandom_range(99) >= 20);
    end

    always @(posedge clk) begin
        if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready)
                      || (cfg_valid && cfg_ready)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("[traffic_matrix_balance_engine] ERROR");
            $finish;
        end
    end

    task automatic send_word(input t_in_word w);
        @(posedge clk);
        if (!no_idle)
            while ($urandom_range(99) < 20) @(posedge clk);
        in_valid <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_word(w);
        n_sent++;
        in_valid <= 1'b0;
    endtask

    task automatic write_dim(input logic [4:0] d);
        while (expect_q.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= d;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        dim_reg = d;
        cfg_valid <= 1'b0;
    endtask

    function automatic t_in_word iw(logic [2:0] c, logic [4:0] r, logic [4:0] k,
                                    logic [63:0] v);
        t_in_word w;
        w.cmd = c; w.row = r; w.col = k; w.value = v;
        return w;
    endfunction

    function automatic t_in_word rand_word(int n, int mode);
        t_in_word w;
        int p;
        logic [63:0] v;
        p = $urandom_range(99);
        w.row = (n > 0 && p < 90) ? 5'($urandom_range(n - 1)) : 5'($urandom_range(31));
        w.col = (n > 0 && p < 90) ? 5'($urandom_range(n - 1)) : 5'($urandom_range(31));
        case ($urandom_range(3))
            0: v = {$urandom, $urandom};
            1: v = 64'($urandom_range(1000));
            2: v = ~64'd0 - 64'($urandom_range(3));
            default: v = {$urandom, $urandom} >> $urandom_range(63);
        endcase
        w.value = v;
        p = $urandom_range(99);
        if (p < 30) w.cmd = CMD_SET;
        else if (p < 48) w.cmd = CMD_ADD;
        else if (p < 58) w.cmd = CMD_SUB;
        else if (p < 78) w.cmd = CMD_GET;
        else if (p < 84) begin
            w.cmd = CMD_SCALE;
            w.value = ($urandom_range(9) == 0) ? 64'd0 :
                      ($urandom_range(3) == 0) ? {$urandom, $urandom} :
                      64'($urandom_range(1, 7));
        end else if (p < 87) w.cmd = CMD_CLEAR;
        else if (p < 97) w.cmd = (mode == 0 || n <= 4) ? CMD_ANALYZE : CMD_GET;
        else w.cmd = 3'd7;
        return w;
    endfunction

    t_dir_row dir_tab [N_DIR];

    initial begin
        t_out_word got;
        int n;
        logic [4:0] dims [6];
        in_valid = 0; in_word = '0; out_ready = 0; cfg_valid = 0; cfg_data = '0;
        hold_out = 0; no_idle = 0; errors = 0; n_sent = 0; n_recv = 0; idle_cycles = 0;
        for (int i = 0; i < 16; i++)
            for (int j = 0; j < 16; j++) mat[i][j] = 0;
        scale_unit = 1;
        dim_reg = DIM_RESET;
        rst_n = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;

        dir_tab[0]  = '{iw(CMD_GET, 0, 0, 0), 1, 64'd0, 1};
        dir_tab[1]  = '{iw(CMD_GET, 15, 15, 0), 1, 64'd0, 1};
        dir_tab[2]  = '{iw(CMD_SET, 0, 0, ~64'd0), 0, 0, 0};
        dir_tab[3]  = '{iw(CMD_GET, 0, 0, 0), 1, ~64'd0, 1};
        dir_tab[4]  = '{iw(CMD_ADD, 0, 0, 64'd2), 0, 0, 0};
        dir_tab[5]  = '{iw(CMD_SUB, 15, 15, 64'd1), 0, 0, 0};
        dir_tab[6]  = '{iw(CMD_SET, 16, 0, 64'd5), 1, 64'd0, 0};
        dir_tab[7]  = '{iw(CMD_GET, 0, 31, 0), 1, 64'd0, 0};
        dir_tab[8]  = '{iw(3'd7, 31, 31, ~64'd0), 1, 64'd0, 0};
        dir_tab[9]  = '{iw(CMD_SCALE, 0, 0, 64'd0), 1, 64'd0, 0};
        dir_tab[10] = '{iw(CMD_SET, 3, 7, 64'h8000_0000_0000_0000), 0, 0, 0};
        dir_tab[11] = '{iw(CMD_SET, 3, 8, 64'h8000_0000_0000_0000), 0, 0, 0};
        dir_tab[12] = '{iw(CMD_ANALYZE, 0, 0, 0), 0, 0, 0};
        dir_tab[13] = '{iw(CMD_SCALE, 0, 0, 64'd3), 0, 0, 0};
        dir_tab[14] = '{iw(CMD_SCALE, 0, 0, ~64'd0), 0, 0, 0};
        dir_tab[15] = '{iw(CMD_GET, 15, 15, 0), 0, 0, 0};
        dir_tab[16] = '{iw(CMD_CLEAR, 0, 0, 0), 1, 64'd0, 1};
        dir_tab[17] = '{iw(CMD_ANALYZE, 0, 0, 0), 0, 0, 0};
        dir_tab[18] = '{iw(CMD_SET, 5, 5, 64'h0123_4567_89ab_cdef), 0, 0, 0};
        dir_tab[19] = '{iw(CMD_SET, 10, 10, 64'hfedc_ba98_7654_3210), 0, 0, 0};
        dir_tab[20] = '{iw(CMD_ADD, 10, 10, 64'h5555_5555_5555_5555), 0, 0, 0};
        dir_tab[21] = '{iw(CMD_SUB, 5, 5, 64'haaaa_aaaa_aaaa_aaaa), 0, 0, 0};
        dir_tab[22] = '{iw(CMD_SCALE, 0, 0, 64'd2), 0, 0, 0};
        dir_tab[23] = '{iw(CMD_ANALYZE, 0, 0, 0), 0, 0, 0};

        for (int i = 0; i < N_DIR; i++) begin
            send_word(dir_tab[i].w);
            if (dir_tab[i].has_exp) begin
                got = expect_q[$];
                if (got.data !== dir_tab[i].exp_data || got.ok !== dir_tab[i].exp_ok) begin
                    $error("table row %0d: data exp %h pred %h", i, dir_tab[i].exp_data,
                           got.data);
                    errors++;
                end
            end
        end

        // dim 0: empty matrix, then small and oversized settings
        write_dim(5'd0);
        send_word(iw(CMD_SET, 0, 0, 64'd1));
        send_word(iw(CMD_ANALYZE, 0, 0, 0));
        write_dim(5'd31);
        send_word(iw(CMD_ANALYZE, 0, 0, 0));
        write_dim(5'd1);
        send_word(iw(CMD_ANALYZE, 0, 0, 0));

        dims = '{5'd2, 5'd3, 5'd16, 5'd4, 5'd1, 5'd20};
        for (int ph = 0; ph < 6; ph++) begin
            write_dim(dims[ph]);
            n = (dims[ph] > 16) ? 16 : dims[ph];
            no_idle = (ph == 2);
            for (int k = 0; k < N_RAND / 6; k++) begin
                if (ph == 1 && k == 10) begin
                    fork
                        begin
                            hold_out = 1;
                            repeat (300) @(posedge clk);
                            hold_out = 0;
                        end
                    join_none
                end
                send_word(rand_word(n, (dims[ph] <= 4) ? 0 : 1));
            end
            no_idle = 0;
        end

        while (expect_q.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        $display("Sent %0d words and checked %0d results over dims 0..31,", n_sent, n_recv);
        $display("with random stalls and a long output hold-off.");
        if (errors == 0 && expect_q.size() == 0)
            $display("[traffic_matrix_balance_engine] OK");
        else
            $display("[traffic_matrix_balance_engine] ERROR");
        $finish;
    end
endmodule
